@@ hw/rtl/lpom_pkg.sv @@
// Shared types and constants of the low-pulse occupancy meter.
package lpom_pkg;

  // Number of sensor channels that hold state.
  localparam int NUM_CHANNELS = 2;

  // Field widths.
  localparam int TimeW = 32;
  localparam int ScaleW = 10;
  localparam int ProdW = TimeW + ScaleW;

  // Occupancy scale factor.
  localparam logic [ScaleW-1:0] OccScale = ScaleW'(1000);

  // Command codes.
  typedef enum logic [1:0] {
    CMD_EDGE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  // Read sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/lpom_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module lpom_div
  import lpom_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ProdW-1:0] dividend,
  input  logic [TimeW-1:0] divisor,
  output logic             done,
  output logic [ProdW-1:0] quotient
);

  localparam int CntW = $clog2(ProdW + 1);

  logic [TimeW-1:0] rem_r;
  logic [ProdW-1:0] quo_r;
  logic [TimeW-1:0] div_r;
  logic [CntW-1:0]  cnt_r;
  logic             done_r;
  logic [TimeW:0]   shifted;
  logic [TimeW:0]   diff;
  logic             fits;

  // One trial subtraction of the shifted remainder.
  always_comb begin
    shifted = {rem_r, quo_r[ProdW-1]};
    diff    = shifted - {1'b0, div_r};
    fits    = (shifted >= {1'b0, div_r});
  end

  // Control: the count runs down from the dividend width to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CntW'(ProdW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[TimeW-1:0] : shifted[TimeW-1:0];
      quo_r <= {quo_r[ProdW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hw/rtl/low_pulse_occupancy_meter.sv @@
// Top level of the two-channel low-pulse occupancy meter.
// Pin edges, start and stop take effect in the cycle they are accepted and
// give no result. A read of an active channel passes through LAUNCH, DIV and
// DONE to a waiting result. The 42-bit product of 1000 and the low total is
// registered at the accept edge. LAUNCH then starts the shared bit-serial
// divider, DIV waits for its registered done flag, and DONE delivers the
// result. A read while stopped or of a zero window skips the divider. The
// block takes no new request while a read is in the divider. It does take a
// request while a finished result waits on the output register. A second
// finished read holds the input off until that register frees up.
module low_pulse_occupancy_meter
  import lpom_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_cmd,
  input  logic             in_channel,
  input  logic             in_pin_level,
  input  logic [TimeW-1:0] in_now_us,
  input  logic [TimeW-1:0] in_now_ms,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_channel,
  output logic [TimeW-1:0] out_occupancy,
  output logic             out_zero_window,
  output logic             out_was_active
);

  state_t           state_r, state_nxt;
  logic [TimeW-1:0] start_us_r [NUM_CHANNELS];
  logic [TimeW-1:0] total_r    [NUM_CHANNELS];
  logic [TimeW-1:0] mark_r     [NUM_CHANNELS];
  logic             active_r;

  logic [ProdW-1:0] prod_r;
  logic [TimeW-1:0] window_r;
  logic             ch_r;
  logic             do_div_r;
  logic             was_active_r;

  logic             out_valid_r;
  logic             out_ch_r;
  logic [TimeW-1:0] out_occ_r;
  logic             out_zw_r;
  logic             out_act_r;

  logic             accept;
  logic             ch_ok;
  cmd_t             cmd;
  logic [TimeW-1:0] window;
  logic             div_start;
  logic             div_done;
  logic [ProdW-1:0] quotient;
  logic [TimeW-1:0] occ_div;
  logic             out_free;
  logic             load_out;

  assign cmd      = cmd_t'(in_cmd);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign ch_ok    = (32'(in_channel) < NUM_CHANNELS);
  assign window   = in_now_ms - mark_r[in_channel];
  assign out_free = !out_valid_r || out_ready;

  // Saturate the quotient to 32 bits.
  assign occ_div = (quotient[ProdW-1:TimeW] != '0) ? '1 : quotient[TimeW-1:0];

  // Per-channel state and the active flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_us_r[i] <= '0;
        total_r[i]    <= '0;
        mark_r[i]     <= '0;
      end
    end else if (accept) begin
      case (cmd)
        CMD_EDGE: begin
          if (active_r && ch_ok) begin
            if (!in_pin_level) begin
              start_us_r[in_channel] <= in_now_us;
            end else begin
              total_r[in_channel] <= total_r[in_channel]
                                     + (in_now_us - start_us_r[in_channel]);
            end
          end
        end
        CMD_READ: begin
          if (active_r && ch_ok) begin
            mark_r[in_channel]  <= in_now_ms;
            total_r[in_channel] <= '0;
          end
        end
        CMD_START: begin
          active_r <= 1'b1;
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            total_r[i] <= '0;
            mark_r[i]  <= in_now_ms;
          end
        end
        default: begin
          active_r <= 1'b0;
        end
      endcase
    end
  end

  // Capture the operands of a read; the product gets its own register.
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_READ) begin
      prod_r       <= ProdW'(total_r[in_channel]) * ProdW'(OccScale);
      window_r     <= window;
      ch_r         <= in_channel;
      do_div_r     <= active_r && ch_ok;
      was_active_r <= active_r;
    end
  end

  // Read sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Read sequencer next state and divider launch.
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && cmd == CMD_READ) begin
          state_nxt = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (do_div_r && window_r != '0) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  lpom_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (window_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch_r  <= ch_r;
      out_act_r <= was_active_r;
      if (!do_div_r) begin
        out_occ_r <= '0;
        out_zw_r  <= 1'b0;
      end else if (window_r == '0) begin
        out_occ_r <= '1;
        out_zw_r  <= 1'b1;
      end else begin
        out_occ_r <= occ_div;
        out_zw_r  <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = out_ch_r;
  assign out_occupancy   = out_occ_r;
  assign out_zero_window = out_zw_r;
  assign out_was_active  = out_act_r;

  // The divider only finishes while the sequencer waits on it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  // A launch always follows an accepted read.
  a_launch_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LAUNCH |-> $past(accept) && $past(cmd == CMD_READ))
    else $error("launch without an accepted read");

  // A zero window can only be flagged for an active read.
  a_zw_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_window |-> out_was_active)
    else $error("zero window flagged on an inactive read");

  // An inactive read reports zero occupancy.
  a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_active |-> out_occupancy == '0)
    else $error("nonzero occupancy on an inactive read");

endmodule
